/* rtl/core/tse_pkg.sv */
// Shared types, codes and calendar helpers for the calendar time-set editor.
package tse_pkg;

	localparam int NUM_FIELDS = 6;

	// Item kinds carried in the mode field.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_KEY  = 2'd1;
	localparam logic [1:0] MODE_RTC  = 2'd2;

	// Key numbers.
	localparam logic [2:0] KEY_MODE = 3'd1;
	localparam logic [2:0] KEY_SEL  = 3'd2;
	localparam logic [2:0] KEY_UP   = 3'd3;
	localparam logic [2:0] KEY_DOWN = 3'd4;

	// Field indexes.
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;
	localparam logic [2:0] FLD_SECOND = 3'd5;

	// Field limits.
	localparam logic [7:0] YEAR_MAX  = 8'd99;
	localparam logic [7:0] MONTH_MAX = 8'd12;
	localparam logic [7:0] HOUR_MAX  = 8'd23;
	localparam logic [7:0] MIN_MAX   = 8'd59;

	localparam logic [15:0] BLINK_RESET = 16'd500;

	// One input word.
	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] key;
		logic [6:0] rtc_year;
		logic [3:0] rtc_month;
		logic [4:0] rtc_day;
		logic [4:0] rtc_hour;
		logic [5:0] rtc_minute;
		logic [5:0] rtc_second;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [6:0] year_out;
		logic [3:0] month_out;
		logic [4:0] day_out;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
		logic       editing;
		logic [2:0] selected_field;
		logic       blank_selected;
		logic       commit;
	} result_t;

	// Editor state; every time field is held at seven bits.
	typedef struct packed {
		logic [NUM_FIELDS-1:0][6:0] fields;
		logic                       edit_mode;
		logic [2:0]                 field_sel;
		logic [15:0]                tick_count;
		logic                       blink_flag;
	} state_t;

	// Days in a month; every fourth year has a leap February.
	function automatic logic [7:0] month_len(input logic [6:0] year, input logic [6:0] month);
		logic [7:0] len;
		len = 8'd31;
		if (month == 7'd2) begin
			len = (year[1:0] == 2'b00) ? 8'd29 : 8'd28;
		end else if (month == 7'd4 || month == 7'd6 || month == 7'd9 || month == 7'd11) begin
			len = 8'd30;
		end
		return len;
	endfunction

endpackage

/* rtl/core/tse_item_if.sv */
// Input channel interface: valid/ready handshake with the key, tick or RTC word.
interface tse_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [2:0] key;
	logic [6:0] rtc_year;
	logic [3:0] rtc_month;
	logic [4:0] rtc_day;
	logic [4:0] rtc_hour;
	logic [5:0] rtc_minute;
	logic [5:0] rtc_second;

	modport source(output valid, mode, key, rtc_year, rtc_month, rtc_day, rtc_hour,
		rtc_minute, rtc_second, input ready);
	modport sink(input valid, mode, key, rtc_year, rtc_month, rtc_day, rtc_hour,
		rtc_minute, rtc_second, output ready);
endinterface

/* rtl/core/tse_result_if.sv */
// Result channel interface: valid/ready handshake with the displayed time and edit status.
interface tse_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] year_out;
	logic [3:0] month_out;
	logic [4:0] day_out;
	logic [4:0] hour_out;
	logic [5:0] minute_out;
	logic [5:0] second_out;
	logic       editing;
	logic [2:0] selected_field;
	logic       blank_selected;
	logic       commit;

	modport source(output valid, year_out, month_out, day_out, hour_out, minute_out,
		second_out, editing, selected_field, blank_selected, commit, input ready);
	modport sink(input valid, year_out, month_out, day_out, hour_out, minute_out,
		second_out, editing, selected_field, blank_selected, commit, output ready);
endinterface

/* rtl/core/tse_step.sv */
// Next-state and result logic for one word of the calendar time-set editor.
module tse_step (
	input  tse_pkg::state_t  cur,
	input  tse_pkg::item_t   itm,
	input  logic [15:0]      blink_period,
	output tse_pkg::state_t  nxt,
	output tse_pkg::result_t res
);

	logic [tse_pkg::NUM_FIELDS-1:0][7:0] up_raw;
	logic [tse_pkg::NUM_FIELDS-1:0][7:0] dn_raw;
	logic [tse_pkg::NUM_FIELDS-1:0][6:0] up_fields;
	logic [tse_pkg::NUM_FIELDS-1:0][6:0] dn_fields;
	logic [7:0]  up_len;
	logic [7:0]  dn_len;
	logic [16:0] tick_inc;
	logic        commit;

	// Step the selected field by one at eight bits so wrap past either end is visible.
	always_comb begin
		for (int i = 0; i < tse_pkg::NUM_FIELDS; i++) begin
			up_raw[i] = {1'b0, cur.fields[i]} + {7'd0, cur.field_sel == 3'(i)};
			dn_raw[i] = {1'b0, cur.fields[i]} - {7'd0, cur.field_sel == 3'(i)};
		end
	end

	// Clean-up after a step up; it applies to every field.
	// A month that wrapped back to January still bounds the day.
	always_comb begin
		up_fields = '0;
		up_fields[tse_pkg::FLD_YEAR] = (up_raw[tse_pkg::FLD_YEAR] > tse_pkg::YEAR_MAX) ?
			7'd0 : up_raw[tse_pkg::FLD_YEAR][6:0];
		up_fields[tse_pkg::FLD_MONTH] = (up_raw[tse_pkg::FLD_MONTH] > tse_pkg::MONTH_MAX) ?
			7'd1 : up_raw[tse_pkg::FLD_MONTH][6:0];
		up_len = tse_pkg::month_len(up_fields[tse_pkg::FLD_YEAR], up_fields[tse_pkg::FLD_MONTH]);
		up_fields[tse_pkg::FLD_DAY] = up_raw[tse_pkg::FLD_DAY][6:0];
		if (up_fields[tse_pkg::FLD_MONTH] != 7'd0 && up_raw[tse_pkg::FLD_DAY] > up_len) begin
			up_fields[tse_pkg::FLD_DAY] = 7'd1;
		end
		up_fields[tse_pkg::FLD_HOUR] = (up_raw[tse_pkg::FLD_HOUR] > tse_pkg::HOUR_MAX) ?
			7'd0 : up_raw[tse_pkg::FLD_HOUR][6:0];
		up_fields[tse_pkg::FLD_MINUTE] = (up_raw[tse_pkg::FLD_MINUTE] > tse_pkg::MIN_MAX) ?
			7'd0 : up_raw[tse_pkg::FLD_MINUTE][6:0];
		up_fields[tse_pkg::FLD_SECOND] = (up_raw[tse_pkg::FLD_SECOND] > tse_pkg::MIN_MAX) ?
			7'd0 : up_raw[tse_pkg::FLD_SECOND][6:0];
	end

	// Clean-up after a step down; bit seven set means the field went below zero.
	always_comb begin
		dn_fields = '0;
		dn_fields[tse_pkg::FLD_YEAR] = dn_raw[tse_pkg::FLD_YEAR][7] ?
			tse_pkg::YEAR_MAX[6:0] : dn_raw[tse_pkg::FLD_YEAR][6:0];
		dn_fields[tse_pkg::FLD_MONTH] =
			(dn_raw[tse_pkg::FLD_MONTH][7] || dn_raw[tse_pkg::FLD_MONTH] == 8'd0) ?
			tse_pkg::MONTH_MAX[6:0] : dn_raw[tse_pkg::FLD_MONTH][6:0];
		dn_len = tse_pkg::month_len(dn_fields[tse_pkg::FLD_YEAR], dn_fields[tse_pkg::FLD_MONTH]);
		dn_fields[tse_pkg::FLD_DAY] = dn_raw[tse_pkg::FLD_DAY][6:0];
		if ({1'b0, dn_fields[tse_pkg::FLD_MONTH]} <= tse_pkg::MONTH_MAX) begin
			if (dn_raw[tse_pkg::FLD_DAY][7] || dn_raw[tse_pkg::FLD_DAY] == 8'd0) begin
				dn_fields[tse_pkg::FLD_DAY] = dn_len[6:0];
			end else if (dn_raw[tse_pkg::FLD_DAY] > dn_len) begin
				dn_fields[tse_pkg::FLD_DAY] = 7'd1;
			end
		end
		dn_fields[tse_pkg::FLD_HOUR] = dn_raw[tse_pkg::FLD_HOUR][7] ?
			tse_pkg::HOUR_MAX[6:0] : dn_raw[tse_pkg::FLD_HOUR][6:0];
		dn_fields[tse_pkg::FLD_MINUTE] = dn_raw[tse_pkg::FLD_MINUTE][7] ?
			tse_pkg::MIN_MAX[6:0] : dn_raw[tse_pkg::FLD_MINUTE][6:0];
		dn_fields[tse_pkg::FLD_SECOND] = dn_raw[tse_pkg::FLD_SECOND][7] ?
			tse_pkg::MIN_MAX[6:0] : dn_raw[tse_pkg::FLD_SECOND][6:0];
	end

	assign tick_inc = {1'b0, cur.tick_count} + 17'd1;

	// Dispatch on the word kind.
	always_comb begin
		nxt = cur;
		commit = 1'b0;
		unique case (itm.mode)
			tse_pkg::MODE_TICK: begin
				if (tick_inc >= {1'b0, blink_period}) begin
					nxt.tick_count = '0;
					nxt.blink_flag = ~cur.blink_flag;
				end else begin
					nxt.tick_count = tick_inc[15:0];
				end
			end
			tse_pkg::MODE_KEY: begin
				if (itm.key == tse_pkg::KEY_MODE) begin
					nxt.edit_mode = ~cur.edit_mode;
					if (!cur.edit_mode) begin
						nxt.field_sel = tse_pkg::FLD_YEAR;
					end else begin
						commit = 1'b1;
					end
				end else if (cur.edit_mode) begin
					unique case (itm.key)
						tse_pkg::KEY_SEL: begin
							nxt.field_sel = (cur.field_sel == tse_pkg::FLD_SECOND) ?
								tse_pkg::FLD_YEAR : cur.field_sel + 3'd1;
						end
						tse_pkg::KEY_UP:   nxt.fields = up_fields;
						tse_pkg::KEY_DOWN: nxt.fields = dn_fields;
						default: ;
					endcase
				end
			end
			tse_pkg::MODE_RTC: begin
				if (!cur.edit_mode) begin
					nxt.fields[tse_pkg::FLD_YEAR]   = itm.rtc_year;
					nxt.fields[tse_pkg::FLD_MONTH]  = {3'd0, itm.rtc_month};
					nxt.fields[tse_pkg::FLD_DAY]    = {2'd0, itm.rtc_day};
					nxt.fields[tse_pkg::FLD_HOUR]   = {2'd0, itm.rtc_hour};
					nxt.fields[tse_pkg::FLD_MINUTE] = {1'b0, itm.rtc_minute};
					nxt.fields[tse_pkg::FLD_SECOND] = {1'b0, itm.rtc_second};
				end
			end
			default: ;
		endcase
	end

	// The result shows the state after the word.
	always_comb begin
		res.year_out       = nxt.fields[tse_pkg::FLD_YEAR];
		res.month_out      = nxt.fields[tse_pkg::FLD_MONTH][3:0];
		res.day_out        = nxt.fields[tse_pkg::FLD_DAY][4:0];
		res.hour_out       = nxt.fields[tse_pkg::FLD_HOUR][4:0];
		res.minute_out     = nxt.fields[tse_pkg::FLD_MINUTE][5:0];
		res.second_out     = nxt.fields[tse_pkg::FLD_SECOND][5:0];
		res.editing        = nxt.edit_mode;
		res.selected_field = nxt.field_sel;
		res.blank_selected = nxt.edit_mode & nxt.blink_flag;
		res.commit         = commit;
	end

endmodule

/* rtl/core/calendar_time_set_editor_top.sv */
// Top level of the calendar time-set editor: input stage, state and result register.
//
// The item channel takes one word per handshake: a millisecond tick, a key press
// (key 1 mode, 2 select, 3 up, 4 down) or a time sample from the real time clock.
// Every accepted word yields exactly one result word on the result channel, in
// order: the six time fields, the edit flag, the selected field, the blank flag
// for blinking the selected field, and a commit strobe on the word that leaves
// edit mode. cfg_we/cfg_wdata write the blink period, in ticks between toggles.
// A word accepted at a clock edge sits in the input register, passes the next-state
// logic and moves into the result register once that register frees up.
// Words go in one per cycle unless the result stalls; the state update is a single
// pass of small compares and adders. The input register and the result register act as a
// two-entry pipeline: when the receiver stalls, the held result stays put, one more
// word waits in the input register, and ready then drops until the result is taken.
// Reset clears the time fields, selects show mode and the year field, clears the
// blink counter and flag, loads a blink period of 500 and empties the pipeline.
module calendar_time_set_editor_top (
	input  logic                clk,
	input  logic                arst_n,
	tse_item_if.sink            item,
	tse_result_if.source        result,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);

	tse_pkg::item_t   item_s1;
	logic             valid_s1;
	tse_pkg::state_t  state_q;
	tse_pkg::state_t  state_nxt;
	tse_pkg::result_t res_nxt;
	tse_pkg::result_t res_q;
	logic             res_valid_q;
	logic [15:0]      blink_period_q;
	logic             advance;

	// The result register frees up when empty or being taken.
	assign advance    = !res_valid_q || result.ready;
	assign item.ready = !valid_s1 || advance;

	// Blink period register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= tse_pkg::BLINK_RESET;
		end else if (cfg_we) begin
			blink_period_q <= cfg_wdata;
		end
	end

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode       <= item.mode;
			item_s1.key        <= item.key;
			item_s1.rtc_year   <= item.rtc_year;
			item_s1.rtc_month  <= item.rtc_month;
			item_s1.rtc_day    <= item.rtc_day;
			item_s1.rtc_hour   <= item.rtc_hour;
			item_s1.rtc_minute <= item.rtc_minute;
			item_s1.rtc_second <= item.rtc_second;
		end
	end

	tse_step u_step (
		.cur          (state_q),
		.itm          (item_s1),
		.blink_period (blink_period_q),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Editor state advances together with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	// Result channel.
	assign result.valid          = res_valid_q;
	assign result.year_out       = res_q.year_out;
	assign result.month_out      = res_q.month_out;
	assign result.day_out        = res_q.day_out;
	assign result.hour_out       = res_q.hour_out;
	assign result.minute_out     = res_q.minute_out;
	assign result.second_out     = res_q.second_out;
	assign result.editing        = res_q.editing;
	assign result.selected_field = res_q.selected_field;
	assign result.blank_selected = res_q.blank_selected;
	assign result.commit         = res_q.commit;

	// A commit is only issued on the word that leaves edit mode.
	a_commit_leaves_edit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.commit |-> !res_q.editing)
		else $error("commit raised while still editing");

	// The blank flag is only shown while editing.
	a_blank_needs_edit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.blank_selected |-> res_q.editing)
		else $error("blank flag set outside edit mode");

	// The selected field never leaves the year..second range.
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.field_sel <= tse_pkg::FLD_SECOND)
		else $error("selected field out of range");

	// A stalled result freezes the editor state.
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> $stable(state_q))
		else $error("state changed while the result was stalled");

	// The held result matches the state it came from.
	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.editing == state_q.edit_mode
			&& res_q.selected_field == state_q.field_sel)
		else $error("result word out of step with editor state");

endmodule
